[src/bced_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bced_pkg
// Shared types and constants for the button click event detector.
// ----------------------------------------------------------------------------
package bced_pkg;

   // Widths of the transfer fields and of the register file
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned EVENT_W = 2;
   localparam int unsigned CFG_W   = 16;
   localparam int unsigned ADDR_W  = 4;
   localparam int unsigned DATA_W  = 32;

   // Action codes
   localparam logic ACT_SCAN  = 1'b0;
   localparam logic ACT_FETCH = 1'b1;

   // Event codes
   localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
   localparam logic [EVENT_W-1:0] EV_CLICK  = 2'd1;
   localparam logic [EVENT_W-1:0] EV_DOUBLE = 2'd2;
   localparam logic [EVENT_W-1:0] EV_LONG   = 2'd3;

   // Register indexes (word address paddr[3:2])
   localparam logic [1:0] REG_DEBOUNCE = 2'd0;
   localparam logic [1:0] REG_LONG     = 2'd1;
   localparam logic [1:0] REG_GAP      = 2'd2;

   // Register reset values
   localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
   localparam logic [CFG_W-1:0] LONG_RST     = 16'd800;
   localparam logic [CFG_W-1:0] GAP_RST      = 16'd300;

   // Timing thresholds handed from the register file to the state machine
   typedef struct packed {
      logic [CFG_W-1:0] debounce_ms;
      logic [CFG_W-1:0] long_press_ms;
      logic [CFG_W-1:0] double_gap_ms;
   } cfg_type;

endpackage

[src/bced_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bced_req_if
// Sample / fetch request channel, valid-ready handshake.
// ----------------------------------------------------------------------------
interface bced_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic        pressed;
   logic [31:0] now_ms;

   modport source (output valid, output action, output pressed, output now_ms,
                   input ready);
   modport sink   (input valid, input action, input pressed, input now_ms,
                   output ready);
endinterface

[src/bced_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bced_rsp_if
// Event result channel, valid-ready handshake.
// ----------------------------------------------------------------------------
interface bced_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_res;

   modport source (output valid, output event_res, input ready);
   modport sink   (input valid, input event_res, output ready);
endinterface

[src/bced_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bced_csr
// APB register file holding the debounce, long-press and double-click gap
// thresholds.
// ----------------------------------------------------------------------------
module bced_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bced_pkg::ADDR_W-1:0]  paddr,
   input  logic [bced_pkg::DATA_W-1:0]  pwdata,
   output logic [bced_pkg::DATA_W-1:0]  prdata,
   output logic                         pready,
   output bced_pkg::cfg_type            cfg
);
   import bced_pkg::*;

   logic             wr_en;
   logic [1:0]       reg_idx;
   logic [CFG_W-1:0] debounce_ff;
   logic [CFG_W-1:0] long_ff;
   logic [CFG_W-1:0] gap_ff;
   logic [CFG_W-1:0] rd_val;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   // register writes; unmapped index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RST;
         long_ff     <= LONG_RST;
         gap_ff      <= GAP_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_DEBOUNCE: debounce_ff <= pwdata[CFG_W-1:0];
            REG_LONG:     long_ff     <= pwdata[CFG_W-1:0];
            REG_GAP:      gap_ff      <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_DEBOUNCE: rd_val = debounce_ff;
         REG_LONG:     rd_val = long_ff;
         REG_GAP:      rd_val = gap_ff;
         default:      rd_val = '0;
      endcase
   end

   assign prdata = {{(DATA_W-CFG_W){1'b0}}, rd_val};

   assign cfg.debounce_ms   = debounce_ff;
   assign cfg.long_press_ms = long_ff;
   assign cfg.double_gap_ms = gap_ff;

endmodule

[src/bced_fsm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bced_fsm
// Six-state button qualifier with timestamp mark and one-entry event buffer.
// Produces the result of the current item combinationally; state advances
// when step is high.
// ----------------------------------------------------------------------------
module bced_fsm (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          action,
   input  logic                          pressed,
   input  logic [bced_pkg::TIME_W-1:0]   now_ms,
   input  bced_pkg::cfg_type             cfg,
   output logic [bced_pkg::EVENT_W-1:0]  event_res
);
   import bced_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_DEBOUNCE  = 3'd1,
      PH_PRESSED   = 3'd2,
      PH_WAIT_REL  = 3'd3,
      PH_REL_PEND  = 3'd4,
      PH_DEBOUNCE2 = 3'd5
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [TIME_W-1:0]  mark_ff, mark_in;
   logic [EVENT_W-1:0] pend_ff, pend_in;
   logic [TIME_W-1:0]  elapsed;
   logic [CFG_W-1:0]   limit;
   logic               expired;

   // wrapping elapsed time against the threshold of the current phase
   assign elapsed = now_ms - mark_ff;

   always_comb begin
      case (phase_ff)
         PH_PRESSED:  limit = cfg.long_press_ms;
         PH_REL_PEND: limit = cfg.double_gap_ms;
         default:     limit = cfg.debounce_ms;
      endcase
   end

   assign expired = elapsed >= {{(TIME_W-CFG_W){1'b0}}, limit};

   // fetch returns the buffered event
   assign event_res = (action == ACT_FETCH) ? pend_ff : EV_NONE;

   // next state
   always_comb begin
      phase_in = phase_ff;
      mark_in  = mark_ff;
      pend_in  = pend_ff;
      if (action == ACT_FETCH) begin
         pend_in = EV_NONE;
      end else begin
         case (phase_ff)
            PH_DEBOUNCE: begin
               if (!pressed) begin
                  phase_in = PH_IDLE;
               end else if (expired) begin
                  phase_in = PH_PRESSED;
                  mark_in  = now_ms;
               end
            end
            PH_PRESSED: begin
               if (!pressed) begin
                  phase_in = PH_REL_PEND;
                  mark_in  = now_ms;
               end else if (expired) begin
                  pend_in  = EV_LONG;
                  phase_in = PH_WAIT_REL;
               end
            end
            PH_REL_PEND: begin
               if (pressed) begin
                  phase_in = PH_DEBOUNCE2;
                  mark_in  = now_ms;
               end else if (expired) begin
                  pend_in  = EV_CLICK;
                  phase_in = PH_IDLE;
               end
            end
            PH_DEBOUNCE2: begin
               // level is looked at only once debounce has run out
               if (expired) begin
                  if (pressed) begin
                     pend_in  = EV_DOUBLE;
                     phase_in = PH_WAIT_REL;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_WAIT_REL: begin
               if (!pressed) phase_in = PH_IDLE;
            end
            default: begin
               if (pressed) begin
                  phase_in = PH_DEBOUNCE;
                  mark_in  = now_ms;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         mark_ff  <= '0;
         pend_ff  <= EV_NONE;
      end else if (step) begin
         phase_ff <= phase_in;
         mark_ff  <= mark_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

[src/button_click_event_detector_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_event_detector_core
// Debounces a sampled push-button level and reports click, double click and
// long press through a one-entry event buffer read by a fetch request.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  req_ch  | in  | valid/ready   | action, pressed, now_ms
//  rsp_ch  | out | valid/ready   | event_res
//  APB     | in  | psel/penable  | paddr, pwdata, prdata (3 x 16-bit regs)
//
//  One request per cycle sustained while rsp_ch.ready stays high; each result is
//  presented on rsp_ch after the input register, then the state update into the
//  result register, and is held there until it transfers.
//  The input and result registers form a two-deep pipe, so a request is taken
//  while an earlier result waits; req_ch stalls only when both are full.
//  Synchronous active-high reset clears the state machine, the event buffer,
//  both valid flags and restores register defaults.
// ----------------------------------------------------------------------------
module button_click_event_detector_core (
   input  logic                         clock,
   input  logic                         reset,
   bced_req_if.sink                     req_ch,
   bced_rsp_if.source                   rsp_ch,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bced_pkg::ADDR_W-1:0]  paddr,
   input  logic [bced_pkg::DATA_W-1:0]  pwdata,
   output logic [bced_pkg::DATA_W-1:0]  prdata,
   output logic                         pready
);
   import bced_pkg::*;

   cfg_type            cfg;
   logic               in_valid_ff, in_valid_in;
   logic               in_action_ff;
   logic               in_pressed_ff;
   logic [TIME_W-1:0]  in_now_ff;
   logic               out_valid_ff, out_valid_in;
   logic [EVENT_W-1:0] out_event_ff;
   logic [EVENT_W-1:0] fsm_event;
   logic               advance;
   logic               take;

   // register file
   bced_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // pipe control
   assign advance      = in_valid_ff & (~out_valid_ff | rsp_ch.ready);
   assign req_ch.ready = ~in_valid_ff | advance;
   assign take         = req_ch.valid & req_ch.ready;

   assign in_valid_in  = take | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_ch.ready);

   // state machine works on the registered request
   bced_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .action    (in_action_ff),
      .pressed   (in_pressed_ff),
      .now_ms    (in_now_ff),
      .cfg       (cfg),
      .event_res (fsm_event)
   );

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         in_action_ff  <= req_ch.action;
         in_pressed_ff <= req_ch.pressed;
         in_now_ff     <= req_ch.now_ms;
      end
      if (advance) begin
         out_event_ff <= fsm_event;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.event_res = out_event_ff;

endmodule

[src/bced_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bced_checker
// Port-level checks for the button click event detector, bound to the core.
// ----------------------------------------------------------------------------
module bced_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_action,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_event
);
   import bced_pkg::*;

   logic fetch_xfer;
   assign fetch_xfer = req_valid & req_ready & (req_action == ACT_FETCH);

   // reset empties the result register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event))
      else $error("stalled result changed");

   // no input backpressure while the result side can drain
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request stalled with free result slot");

   // the second of two back-to-back fetches finds the buffer empty
   a_fetch_clears: assert property (@(posedge clock) disable iff (reset)
      fetch_xfer ##1 (fetch_xfer && rsp_ready) ##1 rsp_ready
      |=> rsp_valid && (rsp_event == EV_NONE))
      else $error("event buffer not cleared by fetch");

endmodule

bind button_click_event_detector_core bced_checker u_bced_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_action (req_ch.action),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_event  (rsp_ch.event_res)
);

[bench/button_click_event_detector_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_event_detector_core_tb
// Self-checking bench for the button click / double click / long press
// detector. A queue of scan and fetch requests feeds a clocked driver. A
// clocked monitor predicts the event code of every accepted request with its
// own copy of the debounce state machine, and checks each returned event in
// order. The run starts with hand-built gestures at reset thresholds. It then
// sweeps several threshold settings, extremes included, with random gestures,
// bounces and noise. Both channels idle at random.
// ----------------------------------------------------------------------------
module button_click_event_detector_core_tb;
   import bced_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned PHASE_ITEMS  = 180;
   localparam int unsigned NUM_SETTINGS = 8;

   // Button machine states, as the block encodes them
   typedef enum logic [2:0] {
      ST_IDLE, ST_DEBOUNCE, ST_HELD, ST_WAIT_RELEASE, ST_RELEASED, ST_DEBOUNCE2
   } btn_state_type;

   typedef struct packed {
      logic              action;
      logic              pressed;
      logic [TIME_W-1:0] now_ms;
   } btn_req_type;

   logic clock = 1'b0;
   logic reset;

   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   bced_req_if req_if ();
   bced_rsp_if rsp_if ();

   button_click_event_detector_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the detector: thresholds, state, timer and event buffer
   logic [CFG_W-1:0]   thr_debounce;
   logic [CFG_W-1:0]   thr_long;
   logic [CFG_W-1:0]   thr_gap;
   btn_state_type      btn_state;
   logic [TIME_W-1:0]  btn_mark;
   logic [EVENT_W-1:0] btn_pending;

   btn_req_type        sample_q[$];
   logic [EVENT_W-1:0] event_q[$];

   bit          req_took;
   bit          rsp_took;
   bit          src_idle_on;
   bit          snk_idle_on;
   int unsigned gap_left;
   int unsigned stall_left;
   int unsigned cycles;
   int unsigned errors;
   int unsigned n_queued;
   int unsigned n_req;
   int unsigned n_fetch;
   int unsigned ev_seen[4];

   // Stimulus time base and the coarsest timestamp step of the current setting
   logic [TIME_W-1:0] sim_now;
   int unsigned       max_step;

   // One request through the shadow machine; returns the expected event code
   function automatic logic [EVENT_W-1:0] predict_event(input logic act,
                                                        input logic down,
                                                        input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0]  held;
      logic [EVENT_W-1:0] ev;
      held = now - btn_mark;
      ev   = EV_NONE;
      if (act == ACT_FETCH) begin
         ev          = btn_pending;
         btn_pending = EV_NONE;
      end else begin
         case (btn_state)
            ST_DEBOUNCE: begin
               if (!down) begin
                  btn_state = ST_IDLE;
               end else if (held >= {16'd0, thr_debounce}) begin
                  btn_state = ST_HELD;
                  btn_mark  = now;
               end
            end
            ST_HELD: begin
               if (!down) begin
                  btn_state = ST_RELEASED;
                  btn_mark  = now;
               end else if (held >= {16'd0, thr_long}) begin
                  btn_pending = EV_LONG;
                  btn_state   = ST_WAIT_RELEASE;
               end
            end
            ST_RELEASED: begin
               if (down) begin
                  btn_state = ST_DEBOUNCE2;
                  btn_mark  = now;
               end else if (held >= {16'd0, thr_gap}) begin
                  btn_pending = EV_CLICK;
                  btn_state   = ST_IDLE;
               end
            end
            // level only looked at once the second debounce has run out
            ST_DEBOUNCE2: begin
               if (held >= {16'd0, thr_debounce}) begin
                  if (down) begin
                     btn_pending = EV_DOUBLE;
                     btn_state   = ST_WAIT_RELEASE;
                  end else begin
                     btn_state = ST_IDLE;
                  end
               end
            end
            ST_WAIT_RELEASE: begin
               if (!down) btn_state = ST_IDLE;
            end
            default: begin
               if (down) begin
                  btn_state = ST_DEBOUNCE;
                  btn_mark  = now;
               end
            end
         endcase
      end
      return ev;
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: check results, predict on request transfers, watchdog
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      logic [EVENT_W-1:0] want;
      req_took = !reset && req_if.valid && req_if.ready;
      rsp_took = !reset && rsp_if.valid && rsp_if.ready;
      if (rsp_took) begin
         if (event_q.size() == 0) begin
            $error("event_res: unexpected result %0d with nothing pending",
                   rsp_if.event_res);
            errors++;
         end else begin
            want = event_q.pop_front();
            if (rsp_if.event_res !== want) begin
               $error("event_res mismatch: expected %0d, actual %0d",
                      want, rsp_if.event_res);
               errors++;
            end
            ev_seen[want]++;
         end
      end
      if (req_took) begin
         event_q.push_back(predict_event(req_if.action, req_if.pressed, req_if.now_ms));
         n_req++;
         if (req_if.action == ACT_FETCH) n_fetch++;
      end
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request driver: holds an item until its transfer, then random gap
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : req_driver
      btn_req_type item;
      if (!reset && (req_took || !req_if.valid)) begin
         if (req_took) gap_left = src_idle_on ? $urandom_range(0, 6) : 0;
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (sample_q.size() > 0) begin
            item = sample_q.pop_front();
            req_if.valid   <= 1'b1;
            req_if.action  <= item.action;
            req_if.pressed <= item.pressed;
            req_if.now_ms  <= item.now_ms;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result side: random stall after each transfer
   always @(negedge clock) begin : rsp_sink
      if (!reset) begin
         if (rsp_took) stall_left = snk_idle_on ? $urandom_range(0, 6) : 0;
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_raw(input logic act, input logic down, input logic [TIME_W-1:0] t);
      btn_req_type item;
      item = '{action: act, pressed: down, now_ms: t};
      sample_q.push_back(item);
      n_queued++;
   endtask

   task automatic push_scan(input logic down, input logic [TIME_W-1:0] t);
      push_raw(ACT_SCAN, down, t);
   endtask

   // fetch ignores level and time, so those are random
   task automatic push_fetch();
      push_raw(ACT_FETCH, 1'($urandom_range(0, 1)), $urandom);
   endtask

   // threshold give or take one coarse step
   function automatic int unsigned near_th(input int unsigned th);
      int unsigned d;
      d = th + $urandom_range(0, 2 * max_step);
      return (d >= max_step) ? d - max_step : 0;
   endfunction

   // Hold one level for about dur ms, with a stray fetch now and then
   task automatic level_run(input logic down, input int unsigned dur);
      logic [TIME_W-1:0] t0;
      t0 = sim_now;
      do begin
         sim_now = sim_now + $urandom_range(0, max_step);
         push_scan(down, sim_now);
         if ($urandom_range(0, 7) == 0) push_fetch();
      end while (sim_now - t0 < dur);
   endtask

   // One random gesture at the current thresholds
   task automatic gesture();
      int unsigned deb;
      int unsigned lng;
      int unsigned gap;
      int unsigned n;
      deb = thr_debounce;
      lng = thr_long;
      gap = thr_gap;
      case ($urandom_range(0, 7))
         0, 1: begin
            level_run(1'b1, near_th(deb) + $urandom_range(0, lng));
            level_run(1'b0, near_th(gap));
         end
         2, 3: begin
            level_run(1'b1, near_th(deb) + $urandom_range(0, lng));
            level_run(1'b0, $urandom_range(0, gap));
            level_run(1'b1, near_th(deb));
            level_run(1'b0, near_th(gap));
         end
         4: begin
            level_run(1'b1, near_th(deb) + near_th(lng));
            level_run(1'b0, near_th(gap));
         end
         // contact bounce: short alternating levels
         5: begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
               level_run(i % 2 == 0, $urandom_range(0, deb + max_step));
         end
         // second press let go before its debounce ends
         6: begin
            level_run(1'b1, deb + $urandom_range(0, lng));
            level_run(1'b0, $urandom_range(0, gap));
            level_run(1'b1, $urandom_range(0, deb));
            level_run(1'b0, near_th(deb) + near_th(gap));
         end
         default: begin
            n = $urandom_range(1, 6);
            repeat (n) push_raw(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
         end
      endcase
      if ($urandom_range(0, 1) == 1) push_fetch();
   endtask

   // Sender holds off until every expected event is back, then lets it settle;
   // checked at the rising edge so the driver's last update has landed
   task automatic wait_idle();
      do @(posedge clock);
      while (sample_q.size() != 0 || req_if.valid || event_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // APB write, then read back through the same register
   task automatic csr_write(input logic [1:0] idx, input logic [CFG_W-1:0] val,
                            input string name);
      logic [DATA_W-1:0] rd;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'd0, val};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rd = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (rd[CFG_W-1:0] !== val) begin
         $error("%s readback mismatch: expected %0d, actual %0d", name, val, rd[CFG_W-1:0]);
         errors++;
      end
      case (idx)
         REG_DEBOUNCE: thr_debounce = val;
         REG_LONG:     thr_long     = val;
         default:      thr_gap      = val;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main
      logic [CFG_W-1:0] d;
      logic [CFG_W-1:0] l;
      logic [CFG_W-1:0] g;
      int unsigned      base;
      bit               paused;

      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req_if.valid   = 1'b0;
      req_if.action  = ACT_SCAN;
      req_if.pressed = 1'b0;
      req_if.now_ms  = '0;
      rsp_if.ready   = 1'b0;
      thr_debounce   = DEBOUNCE_RST;
      thr_long       = LONG_RST;
      thr_gap        = GAP_RST;
      btn_state      = ST_IDLE;
      btn_mark       = '0;
      btn_pending    = EV_NONE;
      src_idle_on    = 1'b1;
      snk_idle_on    = 1'b1;
      sim_now        = '0;
      max_step       = 2;
      paused         = 1'b0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed gestures at reset thresholds (20 / 800 / 300)
      push_raw(ACT_FETCH, 1'b1, 32'hFFFF_FFFF);  // empty buffer
      push_scan(1'b1, 32'hFFFF_FFF0);            // press just below the wrap
      push_scan(1'b1, 32'h0000_0003);            // one ms short of debounce
      push_scan(1'b1, 32'h0000_0004);            // accepted across the wrap
      push_scan(1'b1, 32'd803);
      push_scan(1'b1, 32'd804);                  // long press
      push_raw(ACT_FETCH, 1'b0, 32'd0);
      push_scan(1'b0, 32'd5100);
      push_scan(1'b1, 32'd6000);
      push_scan(1'b0, 32'd6005);                 // bounce back to idle
      push_scan(1'b1, 32'd6010);
      push_scan(1'b1, 32'd6030);
      push_scan(1'b0, 32'd6100);
      push_scan(1'b0, 32'd6399);
      push_scan(1'b0, 32'd6400);                 // single click, left unread
      push_scan(1'b1, 32'd7000);
      push_scan(1'b1, 32'd7020);
      push_scan(1'b0, 32'd7050);
      push_scan(1'b1, 32'd7100);
      push_scan(1'b0, 32'd7110);                 // ignored inside second debounce
      push_scan(1'b1, 32'd7120);                 // double click overwrites click
      push_scan(1'b0, 32'd7200);
      push_fetch();
      push_scan(1'b1, 32'd8000);
      push_scan(1'b1, 32'd8020);
      push_scan(1'b0, 32'd8030);
      push_scan(1'b1, 32'd8040);
      push_scan(1'b0, 32'd8060);                 // released at end of debounce
      push_fetch();                              // no click reported
      wait_idle();

      // Random gestures over a sweep of threshold settings
      for (int p = 0; p < NUM_SETTINGS; p++) begin
         case (p)
            0: begin d = 16'd0;      l = 16'd0;      g = 16'd0;      end
            1: begin d = 16'hFFFF;   l = 16'hFFFF;   g = 16'hFFFF;   end
            2: begin d = DEBOUNCE_RST; l = LONG_RST; g = GAP_RST;    end
            7: begin d = 16'($urandom); l = 16'($urandom); g = 16'($urandom); end
            default: begin
               d = 16'($urandom_range(0, 10));
               l = 16'($urandom_range(0, 60));
               g = 16'($urandom_range(0, 40));
            end
         endcase
         csr_write(REG_DEBOUNCE, d, "debounce_ms");
         csr_write(REG_LONG, l, "long_press_ms");
         csr_write(REG_GAP, g, "double_gap_ms");
         @(posedge clock);
         max_step    = ((d > l) ? ((d > g) ? d : g) : ((l > g) ? l : g)) / 6 + 2;
         src_idle_on = (p != 0) && ($urandom_range(0, 3) != 0);
         snk_idle_on = (p != 0) && ($urandom_range(0, 3) != 0);
         if (p == 1) sim_now = 32'hFFFF_0000;
         if (p == 4) sim_now = 32'hFFFF_FFC0;
         base = n_queued;
         while (n_queued - base < PHASE_ITEMS) begin
            gesture();
            // sender holds off mid-setting until the result side has caught up
            if (p == 3 && !paused && n_queued - base >= PHASE_ITEMS / 2) begin
               wait_idle();
               paused = 1'b1;
            end
         end
         wait_idle();
      end

      $display("Covered %0d request transfers (%0d fetches) over %0d threshold settings",
               n_req, n_fetch, NUM_SETTINGS + 1);
      $display("Fetched events: %0d clicks, %0d double clicks, %0d long presses",
               ev_seen[EV_CLICK], ev_seen[EV_DOUBLE], ev_seen[EV_LONG]);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
